>>> rtl/core/vtsi_pkg.sv
package vtsi_pkg;

    localparam int NUM_CH    = 6;
    localparam int CH_W      = 32;
    localparam int STAMP_W   = 32;
    localparam int PROD_W    = 65;
    localparam int MAG_W     = 64;
    localparam int DIV_STEPS = 64;
    localparam int STEP_W    = 7;

    localparam logic [STAMP_W-1:0] MAX_GAP_RESET = 32'd200000;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_SYNC = 1'b1;

    typedef logic signed [CH_W-1:0] chan_t;

    // bracket weights handed to every lane
    typedef struct packed {
        logic [STAMP_W-1:0] wf;
        logic [STAMP_W-1:0] wb;
        logic [STAMP_W-1:0] d;
    } weight_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

endpackage

>>> rtl/core/vtsi_if.sv
interface vtsi_in_if;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [31:0]         stamp;
    logic signed [31:0]  lin_x;
    logic signed [31:0]  lin_y;
    logic signed [31:0]  lin_z;
    logic signed [31:0]  ang_x;
    logic signed [31:0]  ang_y;
    logic signed [31:0]  ang_z;

    modport source (output valid, operation, stamp, lin_x, lin_y, lin_z,
                    ang_x, ang_y, ang_z, input ready);
    modport sink   (input valid, operation, stamp, lin_x, lin_y, lin_z,
                    ang_x, ang_y, ang_z, output ready);
endinterface

interface vtsi_out_if;
    logic                valid;
    logic                ready;
    logic                ok;
    logic [31:0]         out_stamp;
    logic signed [31:0]  out_lin_x;
    logic signed [31:0]  out_lin_y;
    logic signed [31:0]  out_lin_z;
    logic signed [31:0]  out_ang_x;
    logic signed [31:0]  out_ang_y;
    logic signed [31:0]  out_ang_z;

    modport source (output valid, ok, out_stamp, out_lin_x, out_lin_y, out_lin_z,
                    out_ang_x, out_ang_y, out_ang_z, input ready);
    modport sink   (input valid, ok, out_stamp, out_lin_x, out_lin_y, out_lin_z,
                    out_ang_x, out_ang_y, out_ang_z, output ready);
endinterface

>>> rtl/core/vtsi_lane.sv
module vtsi_lane #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [$clog2(FIFO_DEPTH)-1:0]      wr_addr,
    input  vtsi_pkg::chan_t                    wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(FIFO_DEPTH)-1:0]      rd_addr0,
    input  logic [$clog2(FIFO_DEPTH)-1:0]      rd_addr1,
    input  logic                               start,
    input  vtsi_pkg::weight_t                  weight,
    output vtsi_pkg::lane_stat_t               status,
    output vtsi_pkg::chan_t                    result
);
    import vtsi_pkg::*;

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_SUM, L_DIV, L_DONE} lstate_t;

    chan_t                 mem [FIFO_DEPTH];
    chan_t                 vf_reg, vb_reg;
    lstate_t               state_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic [STAMP_W-1:0]    d_reg;
    logic                  neg_reg;
    logic [STAMP_W:0]      rem_reg;
    logic [MAG_W-1:0]      num_reg;
    logic [STEP_W-1:0]     step_reg;
    chan_t                 result_reg;

    logic signed [PROD_W:0] sum;
    logic [MAG_W-1:0]       mag;
    logic [STAMP_W:0]       rem_shift;
    logic                   qbit;
    logic [MAG_W-1:0]       quot;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            vf_reg <= mem[rd_addr0];
            vb_reg <= mem[rd_addr1];
        end
    end

    always_comb
    begin
        sum       = {p0_reg[PROD_W-1], p0_reg} + {p1_reg[PROD_W-1], p1_reg};
        mag       = sum[PROD_W] ? MAG_W'(-sum) : MAG_W'(sum);
        rem_shift = {rem_reg[STAMP_W-1:0], num_reg[MAG_W-1]};
        qbit      = (rem_shift >= {1'b0, d_reg});
        quot      = neg_reg ? -num_reg : num_reg;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    d_reg  <= weight.d;
                    p0_reg <= PROD_W'(vf_reg * $signed({1'b0, weight.wf}));
                    p1_reg <= PROD_W'(vb_reg * $signed({1'b0, weight.wb}));
                    result_reg <= vf_reg;
                end
            end
            L_SUM:
            begin
                neg_reg  <= sum[PROD_W];
                num_reg  <= mag;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            L_DIV:
            begin
                rem_reg  <= qbit ? rem_shift - {1'b0, d_reg} : rem_shift;
                num_reg  <= {num_reg[MAG_W-2:0], qbit};
                step_reg <= step_reg + 1'b1;
            end
            L_DONE:
            begin
                result_reg <= (d_reg == '0) ? result_reg : chan_t'(quot[CH_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
        end
        else
        begin
            case (state_reg)
                L_IDLE: if (start) state_reg <= L_MUL;
                L_MUL:  state_reg <= L_SUM;
                L_SUM:  state_reg <= (d_reg == '0) ? L_DONE : L_DIV;
                L_DIV:  if (step_reg == STEP_W'(DIV_STEPS - 1)) state_reg <= L_DONE;
                L_DONE: state_reg <= L_IDLE;
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign status.busy = (state_reg != L_IDLE);
    assign status.done = (state_reg == L_DONE);
    assign result      = result_reg;

endmodule

>>> rtl/core/velocity_timestamp_sync_interp.sv
// Push: one push per cycle while no sync is in progress (ready only when idle).
// Sync: reads the bracket times through the registered time store, pops stale
//   samples, then the lanes multiply, sum, run a 64-step divide and finish; equal
//   bracket times skip the divide and a failed sync skips the lanes.
// A new transfer is taken only once the sync result is loaded into the output register.
// Reset: asynchronous, active low; empties the FIFO, reloads max_gap to 200000.
// Sample stores hold no reset and need no clearing pass.
module velocity_timestamp_sync_interp #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    vtsi_in_if.sink     sample_in,
    vtsi_out_if.source  result_out,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);
    import vtsi_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_LANE, S_DONE} state_t;

    state_t              state_reg;
    logic [AW-1:0]       head_reg;
    logic [CW-1:0]       count_reg;
    logic [STAMP_W-1:0]  gap_reg;
    logic [STAMP_W-1:0]  t_reg;
    logic [STAMP_W-1:0]  f_reg, b_reg;
    logic                ok_reg;

    // time store, two registered read ports
    logic [STAMP_W-1:0]  time_mem [FIFO_DEPTH];

    // output holding register parts the result side from the sequencer
    logic                ov_reg;
    logic                ook_reg;
    logic [STAMP_W-1:0]  ostamp_reg;
    chan_t               ores_reg [NUM_CH];

    chan_t               ch_in  [NUM_CH];
    chan_t               lane_res [NUM_CH];
    lane_stat_t          lane_st [NUM_CH];
    logic [NUM_CH-1:0]   lane_done;

    logic                push_acc, sync_acc;
    logic                full;
    logic [AW-1:0]       head_eff, head_nx, wr_ptr;
    logic [CW-1:0]       count_eff;
    logic [CW:0]         wsum;
    logic                rd_en, start;
    weight_t             weight;
    logic                fail_pop, gap_bad;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == AW'(FIFO_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    assign sample_in.ready = (state_reg == S_IDLE);
    assign push_acc = sample_in.valid && sample_in.ready && (sample_in.operation == OP_PUSH);
    assign sync_acc = sample_in.valid && sample_in.ready && (sample_in.operation == OP_SYNC);

    // push slot: drop the oldest first when full
    always_comb
    begin
        full      = (count_reg == FULL);
        head_eff  = full ? wrap_inc(head_reg) : head_reg;
        count_eff = full ? FULL - 1'b1 : count_reg;
        wsum      = {1'b0, CW'(head_eff)} + {1'b0, count_eff};
        if (wsum >= (CW+1)'(FIFO_DEPTH))
        begin
            wsum = wsum - (CW+1)'(FIFO_DEPTH);
        end
        wr_ptr    = wsum[AW-1:0];
        head_nx   = wrap_inc(head_reg);
        rd_en     = (state_reg == S_RD);
        gap_bad   = ((t_reg - f_reg) > gap_reg) || ((b_reg - t_reg) > gap_reg);
        fail_pop  = (b_reg >= t_reg) && gap_bad;
        start     = (state_reg == S_CHK) && (f_reg <= t_reg) && (b_reg >= t_reg) && !gap_bad;
        weight.wf = b_reg - t_reg;
        weight.wb = t_reg - f_reg;
        weight.d  = b_reg - f_reg;
    end

    assign ch_in[0] = sample_in.lin_x;
    assign ch_in[1] = sample_in.lin_y;
    assign ch_in[2] = sample_in.lin_z;
    assign ch_in[3] = sample_in.ang_x;
    assign ch_in[4] = sample_in.ang_y;
    assign ch_in[5] = sample_in.ang_z;

    // one lane per velocity channel, all started together
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        vtsi_lane #(.FIFO_DEPTH(FIFO_DEPTH)) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (push_acc),
            .wr_addr  (wr_ptr),
            .wr_data  (ch_in[c]),
            .rd_en    (rd_en),
            .rd_addr0 (head_reg),
            .rd_addr1 (head_nx),
            .start    (start),
            .weight   (weight),
            .status   (lane_st[c]),
            .result   (lane_res[c])
        );
        assign lane_done[c] = lane_st[c].done;
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            time_mem[wr_ptr] <= sample_in.stamp;
        end
        if (rd_en)
        begin
            f_reg <= time_mem[head_reg];
            b_reg <= time_mem[head_nx];
        end
        if (sync_acc)
        begin
            t_reg <= sample_in.stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            gap_reg   <= MAX_GAP_RESET;
            ok_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gap_reg <= cfg_data;
            end
            // load a finished result, or drop the one just taken
            if ((state_reg == S_DONE) && (!ov_reg || result_out.ready))
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && result_out.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (push_acc)
                    begin
                        head_reg  <= head_eff;
                        count_reg <= count_eff + 1'b1;
                    end
                    else if (sync_acc)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    // fewer than two samples: fail, keep the FIFO
                    if (count_reg < CW'(2))
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (f_reg > t_reg)
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else if (b_reg < t_reg)
                    begin
                        // advance past a stale sample and look again
                        head_reg  <= head_nx;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_RD;
                    end
                    else if (fail_pop)
                    begin
                        head_reg  <= head_nx;
                        count_reg <= count_reg - 1'b1;
                        ok_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ok_reg    <= 1'b1;
                        state_reg <= S_LANE;
                    end
                end
                S_LANE:
                begin
                    if (&lane_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!ov_reg || result_out.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // merge: gather the lane results into the output register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && (!ov_reg || result_out.ready))
        begin
            ook_reg    <= ok_reg;
            ostamp_reg <= t_reg;
            for (int c = 0; c < NUM_CH; c++)
            begin
                ores_reg[c] <= ok_reg ? lane_res[c] : '0;
            end
        end
    end

    assign result_out.valid     = ov_reg;
    assign result_out.ok        = ook_reg;
    assign result_out.out_stamp = ostamp_reg;
    assign result_out.out_lin_x = ores_reg[0];
    assign result_out.out_lin_y = ores_reg[1];
    assign result_out.out_lin_z = ores_reg[2];
    assign result_out.out_ang_x = ores_reg[3];
    assign result_out.out_ang_y = ores_reg[4];
    assign result_out.out_ang_z = ores_reg[5];

endmodule

>>> rtl/core/vtsi_checker.sv
module vtsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ok,
    input logic [31:0] out_stamp,
    input logic [31:0] out_lin_x,
    input logic [31:0] out_ang_z
);
    import vtsi_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_stamp) && $stable(out_ok))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ok |-> out_lin_x == '0 && out_ang_z == '0)
        else $error("failed sync carries non-zero channels");

    a_sync_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op == OP_SYNC |=> !in_ready)
        else $error("new transfer taken during a sync");

endmodule

bind velocity_timestamp_sync_interp vtsi_checker u_vtsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .in_op     (sample_in.operation),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_ok    (result_out.ok),
    .out_stamp (result_out.out_stamp),
    .out_lin_x (result_out.out_lin_x),
    .out_ang_z (result_out.out_ang_z)
);
